@@ hdl/assert_macros.svh @@
// Assertion helpers used by the cache engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/lfu_pkg.sv @@
`default_nettype none
package lfu_pkg;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 31;
  localparam int CAP_W  = 5;
  localparam int CAP_RESET = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [KEY_W-1:0]  lookup_key;
    logic [DATA_W-1:0] store_value;
  } lfu_in_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
  } lfu_out_t;
endpackage
`default_nettype wire

@@ hdl/lfu_fifo.sv @@
`default_nettype none
// Small request queue between the front end and the cache engine
module lfu_fifo
  import lfu_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          wr_valid,
  output logic         wr_ready,
  input  lfu_in_t      wr_data,
  output logic         rd_valid,
  input  wire          rd_ready,
  output lfu_in_t      rd_data
);
  lfu_in_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // store payload
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule
`default_nettype wire

@@ hdl/lfu_engine.sv @@
`default_nettype none
// Cache engine: match, victim search, update, result register
module lfu_engine
  import lfu_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire [CAP_W-1:0]  cap,
  input  wire              req_valid,
  output logic             req_ready,
  input  lfu_in_t          req,
  output logic             out_valid,
  input  wire              out_ready,
  output lfu_out_t         out_data
);
  `include "assert_macros.svh"

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int RW = IW;
  localparam int LW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_VICT  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]             st_r;
  lfu_in_t                cur_r;
  logic [CAPACITY-1:0]    vld_r;
  logic [KEY_W-1:0]       key_r [CAPACITY];
  logic [DATA_W-1:0]      dat_r [CAPACITY];
  logic [COUNT_WIDTH-1:0] cnt_r [CAPACITY];
  logic [RW-1:0]          rnk_r [CAPACITY];
  logic [OW-1:0]          occ_r;
  logic                   hit_r, en_r, evict_r;
  logic [IW-1:0]          hidx_r;

  // effective capacity
  logic [OW:0] cap_eff;
  always_comb begin
    if (int'(cap) > CAPACITY)
      cap_eff = (OW+1)'(CAPACITY);
    else
      cap_eff = (OW+1)'(cap);
  end

  // key match and free slot search
  logic [CAPACITY-1:0] mvec;
  logic [IW-1:0]       midx, fidx;
  logic                mhit, fany;
  always_comb begin
    midx = '0; mhit = 1'b0; fidx = '0; fany = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      mvec[i] = vld_r[i] && (key_r[i] == cur_r.lookup_key);
      if (mvec[i] && !mhit) begin mhit = 1'b1; midx = IW'(i); end
      if (!vld_r[i] && !fany) begin fany = 1'b1; fidx = IW'(i); end
    end
  end

  // victim: lowest count, then largest rank, via a tree over valid entries
  typedef struct packed {
    logic                   v;
    logic [COUNT_WIDTH-1:0] c;
    logic [RW-1:0]          r;
    logic [IW-1:0]          i;
  } cand_t;
  localparam int NP = 1 << LW;
  cand_t tree [2*NP];
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (i < CAPACITY) begin
        tree[NP+i] = '{v: vld_r[i], c: cnt_r[i], r: rnk_r[i], i: IW'(i)};
      end else begin
        tree[NP+i] = '0;
      end
    end
    tree[0] = '0;
    for (int n = NP-1; n >= 1; n--) begin
      if (!tree[2*n+1].v) tree[n] = tree[2*n];
      else if (!tree[2*n].v) tree[n] = tree[2*n+1];
      else if (tree[2*n+1].c < tree[2*n].c ||
               (tree[2*n+1].c == tree[2*n].c && tree[2*n+1].r > tree[2*n].r))
        tree[n] = tree[2*n+1];
      else tree[n] = tree[2*n];
    end
  end
  cand_t vict;
  assign vict = (NP == 1) ? tree[1] : tree[1];

  assign req_ready = (st_r == S_IDLE) && !out_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r)
        S_IDLE:  if (req_valid && req_ready) st_r <= S_MATCH;
        S_MATCH: st_r <= S_VICT;
        S_VICT:  st_r <= S_WRITE;
        S_WRITE: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // update state and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      occ_r     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        cnt_r[i] <= '0;
        rnk_r[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (req_valid && req_ready) cur_r <= req;
        end
        S_MATCH: begin
          hit_r   <= mhit;
          hidx_r  <= midx;
          en_r    <= (cap_eff != '0);
          evict_r <= !mhit && ((OW+1)'(occ_r) >= cap_eff);
        end
        S_VICT: begin
          // drop the victim and close the rank gap
          if (en_r && cur_r.operation == OP_PUT && evict_r && vict.v) begin
            for (int i = 0; i < CAPACITY; i++)
              if (vld_r[i] && rnk_r[i] > vict.r) rnk_r[i] <= rnk_r[i] - RW'(1);
            vld_r[vict.i] <= 1'b0;
            occ_r <= occ_r - OW'(1);
          end
        end
        S_WRITE: begin
          if (cur_r.operation == OP_GET) begin
            out_valid           <= 1'b1;
            out_data.found      <= en_r && hit_r;
            out_data.read_value <= (en_r && hit_r) ? dat_r[hidx_r] : '0;
          end
          if (en_r && hit_r) begin
            // touch: bump count, make most recent
            for (int i = 0; i < CAPACITY; i++)
              if (vld_r[i] && rnk_r[i] < rnk_r[hidx_r]) rnk_r[i] <= rnk_r[i] + RW'(1);
            rnk_r[hidx_r] <= '0;
            if (cnt_r[hidx_r] != '1) cnt_r[hidx_r] <= cnt_r[hidx_r] + COUNT_WIDTH'(1);
            if (cur_r.operation == OP_PUT) dat_r[hidx_r] <= cur_r.store_value;
          end else if (en_r && cur_r.operation == OP_PUT && fany) begin
            for (int i = 0; i < CAPACITY; i++)
              if (vld_r[i]) rnk_r[i] <= rnk_r[i] + RW'(1);
            vld_r[fidx]  <= 1'b1;
            key_r[fidx]  <= cur_r.lookup_key;
            dat_r[fidx]  <= cur_r.store_value;
            cnt_r[fidx]  <= COUNT_WIDTH'(1);
            rnk_r[fidx]  <= '0;
            occ_r        <= occ_r + OW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `CHK_IMPL(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OW'(CAPACITY), "occupancy above capacity")
  `CHK_IMPL(a_occ_cnt, clk, rst_n, st_r == S_IDLE, $countones(vld_r) == 32'(occ_r), "occupancy mismatch")
  `CHK_NEXT(a_out_get, clk, rst_n, st_r == S_WRITE && cur_r.operation == OP_GET, out_valid, "get result lost")
endmodule
`default_nettype wire

@@ hdl/lfu_cache_lru_tiebreak.sv @@
`default_nettype none
// LFU cache with LRU tie-break, fully associative, CAPACITY entries.
// Input channel in_valid/in_ready/in_data carries get or put requests.
// Output channel out_valid/out_ready/out_data returns one result per get
// (found flag and value); a put returns nothing.
// cfg_we/cfg_wdata set the capacity in use (reset 16; zero disables);
// write it only while the cache is idle and empty.
// A two-entry request queue sits in front of the engine. The engine takes
// one request at a time and steps it through its sequencer states (accept,
// match, victim search, update and result); it takes no new request until
// it is back in accept and the result register has been freed.
// Reset empties the cache and the queue.
// While out_ready is low the result waits in its register, the engine
// holds the next request, and the queue keeps accepting until full.
module lfu_cache_lru_tiebreak
  import lfu_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  lfu_in_t          in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output lfu_out_t         out_data,
  input  wire              cfg_we,
  input  wire [CAP_W-1:0]  cfg_wdata
);
  logic [CAP_W-1:0] cap_r;
  logic             q_valid, q_ready;
  lfu_in_t          q_data;

  // hold capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_W'(CAP_RESET);
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lfu_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  lfu_engine #(.CAPACITY(CAPACITY), .COUNT_WIDTH(COUNT_WIDTH)) u_engine (
    .clk(clk), .rst_n(rst_n), .cap(cap_r),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule
`default_nettype wire
